### rtl/core/utf8d_pkg.sv
package utf8d_pkg;

  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] LEAD2_MIN  = 8'hC2;
  localparam logic [7:0] LEAD3_LOW  = 8'hE0;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] SECOND_A0  = 8'hA0;
  localparam logic [7:0] LEAD4_LOW  = 8'hF0;
  localparam logic [7:0] SECOND_90  = 8'h90;
  localparam logic [7:0] LEAD4_MAX  = 8'hF4;
  localparam logic [7:0] SECOND_8F  = 8'h8F;

  localparam logic [2:0] LEN_BAD  = 3'd0;
  localparam logic [2:0] LEN_ONE  = 3'd1;
  localparam logic [2:0] LEN_TWO  = 3'd2;
  localparam logic [2:0] LEN_FOUR = 3'd4;
  localparam logic [2:0] LEN_THREE = 3'd3;

  localparam int unsigned CP_W = 21;

  typedef logic [2:0] len_t;

  // first pipeline stage: raw window plus lead class
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    len_t       need;
    len_t       avail;
    logic [3:1] cont;
  } s1_t;

  typedef struct packed {
    logic ok;
    len_t len;
  } chk_t;

  function automatic len_t lead_len(input logic [7:0] b);
    len_t r;
    r = LEN_BAD;
    if (b[7] == 1'b0)            r = LEN_ONE;
    else if (b[7:5] == 3'b110)   r = LEN_TWO;
    else if (b[7:4] == 4'b1110)  r = LEN_THREE;
    else if (b[7:3] == 5'b11110) r = LEN_FOUR;
    return r;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_TAG;
  endfunction

endpackage

### rtl/core/utf8d_if.sv
interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_first;
  logic [7:0] byte_second;
  logic [7:0] byte_third;
  logic [7:0] byte_fourth;
  logic [2:0] bytes_available;

  modport source (output valid, byte_first, byte_second, byte_third, byte_fourth,
                  bytes_available, input ready);
  modport sink   (input valid, byte_first, byte_second, byte_third, byte_fourth,
                  bytes_available, output ready);
endinterface

interface utf8d_out_if;
  logic                        valid;
  logic                        ready;
  logic [utf8d_pkg::CP_W-1:0]  scalar_value;
  logic [2:0]                  char_length;
  logic                        decode_ok;

  modport source (output valid, scalar_value, char_length, decode_ok, input ready);
  modport sink   (input valid, scalar_value, char_length, decode_ok, output ready);
endinterface

### rtl/core/utf8d_check.sv
module utf8d_check (
  input  utf8d_pkg::s1_t  s1,
  output utf8d_pkg::chk_t chk
);

  logic conts_ok;
  logic form_ok;

  always_comb begin
    conts_ok = 1'b1;
    form_ok  = 1'b1;
    unique case (s1.need)
      utf8d_pkg::LEN_ONE: begin
        conts_ok = 1'b1;
      end
      utf8d_pkg::LEN_TWO: begin
        conts_ok = s1.cont[1];
        form_ok  = s1.b0 >= utf8d_pkg::LEAD2_MIN;
      end
      utf8d_pkg::LEN_THREE: begin
        conts_ok = s1.cont[1] & s1.cont[2];
        // reject overlong and surrogate ranges
        form_ok  = !((s1.b0 == utf8d_pkg::LEAD3_LOW) && (s1.b1 < utf8d_pkg::SECOND_A0))
                && !((s1.b0 == utf8d_pkg::LEAD3_SURR) && (s1.b1 >= utf8d_pkg::SECOND_A0));
      end
      utf8d_pkg::LEN_FOUR: begin
        conts_ok = &s1.cont;
        form_ok  = !((s1.b0 == utf8d_pkg::LEAD4_LOW) && (s1.b1 < utf8d_pkg::SECOND_90))
                && (s1.b0 <= utf8d_pkg::LEAD4_MAX)
                && !((s1.b0 == utf8d_pkg::LEAD4_MAX) && (s1.b1 > utf8d_pkg::SECOND_8F));
      end
      default: begin
        conts_ok = 1'b0;
        form_ok  = 1'b0;
      end
    endcase
  end

  assign chk.ok  = conts_ok && form_ok && (s1.avail >= s1.need);
  assign chk.len = chk.ok ? s1.need : utf8d_pkg::LEN_BAD;

endmodule

### rtl/core/utf8_strict_char_decoder_top.sv
// channel | dir | payload
// req     | in  | byte_first, byte_second, byte_third, byte_fourth, bytes_available
// rsp     | out | scalar_value, char_length, decode_ok
//
// Three register stages: classify, check, assemble.
// One word enters per cycle when rsp is not stalled.
// rst (synchronous) clears the stage valid bits only.
// A stall on rsp holds each full stage; empty stages still fill behind it.
module utf8_strict_char_decoder_top (
  input logic clk,
  input logic rst,
  utf8d_in_if.sink    req,
  utf8d_out_if.source rsp
);

  utf8d_pkg::s1_t  s1, s1_next;
  utf8d_pkg::chk_t chk;
  logic [7:0]      b0_2, b1_2, b2_2, b3_2;
  utf8d_pkg::chk_t c2;
  logic            v1, v2, v3;
  logic            r1, r2, r3;
  logic [utf8d_pkg::CP_W-1:0] cp_next;
  logic [utf8d_pkg::CP_W-1:0] scalar_value;
  logic [2:0]      char_length;
  logic            decode_ok;

  assign r3 = !v3 || rsp.ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign req.ready = r1;

  always_comb begin
    s1_next.b0    = req.byte_first;
    s1_next.b1    = req.byte_second;
    s1_next.b2    = req.byte_third;
    s1_next.b3    = req.byte_fourth;
    s1_next.need  = utf8d_pkg::lead_len(req.byte_first);
    // availability above four means the whole window
    s1_next.avail = (req.bytes_available > utf8d_pkg::LEN_FOUR) ? utf8d_pkg::LEN_FOUR
                                                                : req.bytes_available;
    s1_next.cont  = {utf8d_pkg::is_cont(req.byte_fourth),
                     utf8d_pkg::is_cont(req.byte_third),
                     utf8d_pkg::is_cont(req.byte_second)};
  end

  utf8d_check u_check (
    .s1  (s1),
    .chk (chk)
  );

  always_comb begin
    unique case (c2.len)
      utf8d_pkg::LEN_ONE:   cp_next = {14'd0, b0_2[6:0]};
      utf8d_pkg::LEN_TWO:   cp_next = {10'd0, b0_2[4:0], b1_2[5:0]};
      utf8d_pkg::LEN_THREE: cp_next = {5'd0, b0_2[3:0], b1_2[5:0], b2_2[5:0]};
      utf8d_pkg::LEN_FOUR:  cp_next = {b0_2[2:0], b1_2[5:0], b2_2[5:0], b3_2[5:0]};
      default:              cp_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (r1) v1 <= req.valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (r1 && req.valid) s1 <= s1_next;
    if (r2 && v1) begin
      b0_2 <= s1.b0;
      b1_2 <= s1.b1;
      b2_2 <= s1.b2;
      b3_2 <= s1.b3;
      c2   <= chk;
    end
    if (r3 && v2) begin
      scalar_value <= cp_next;
      char_length  <= c2.len;
      decode_ok    <= c2.ok;
    end
  end

  assign rsp.valid        = v3;
  assign rsp.scalar_value = scalar_value;
  assign rsp.char_length  = char_length;
  assign rsp.decode_ok    = decode_ok;

`ifndef SYNTHESIS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.decode_ok) |-> (rsp.char_length == 3'd0 && rsp.scalar_value == 21'd0))
    else $error("error word carries nonzero fields");

  a_ok_len: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.decode_ok) |-> (rsp.char_length != 3'd0 && rsp.char_length <= 3'd4))
    else $error("valid word with bad length");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> v1)
    else $error("accepted word lost at stage one");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !r2) |=> (v2 && $stable(c2)))
    else $error("stalled stage two changed");
`endif

endmodule
